/* src/itda_pkg.sv */
// Package for the decimal ASCII converter: shared types and constants.
package itda_pkg;

  // ASCII codes emitted by the converter
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // Command codes carried with each input item
  localparam logic CMD_SIGNED   = 1'b0;
  localparam logic CMD_UNSIGNED = 1'b1;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_EMIT
  } back_state_t;

  // Status of the back end, watched at the top level
  typedef struct packed {
    logic busy;
    logic converting;
  } back_status_t;

endpackage

/* src/itda_if.sv */
// Channel interfaces: input word items and output character items.
interface itda_word_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] value;
  logic                 command;

  modport source (output valid, output value, output command, input ready);
  modport sink   (input valid, input value, input command, output ready);
endinterface

interface itda_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

/* src/int_to_decimal_ascii_top.sv */
// Flow: an item passes through the queue and is converted to BCD bit-serially in the back end;
// its characters then come out MSD first, leading zeros dropped, a minus sign first.
// The back end takes a new item only after it has registered the last character of the
// previous one.
// A two-entry queue lets the front accept items while the back end works.
// Reset (rst, synchronous, active high) empties the queue and idles the back end.
module int_to_decimal_ascii_top #(
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  itda_word_if.sink   words,
  itda_char_if.source chars
);

  logic                   push_valid;
  logic [WORD_BITS:0]     push_data;
  logic                   push_ready;
  logic                   q_valid;
  logic [WORD_BITS:0]     q_data;
  logic                   q_ready;
  itda_pkg::back_status_t back_status;

  itda_front #(.WORD_BITS(WORD_BITS)) u_front (
    .words      (words),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  itda_queue #(.WIDTH(WORD_BITS + 1)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop_ready  (q_ready)
  );

  itda_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .pop_ready (q_ready),
    .chars     (chars),
    .status    (back_status)
  );

`ifndef SYNTHESIS
  // An item accepted into an empty queue is visible to the back end next cycle
  a_queue_fill: assert property (@(posedge clk) disable iff (rst)
    (words.valid && words.ready && !q_valid) |=> q_valid)
    else $error("accepted item did not reach the queue");

  // Taking an item from the queue starts the back end
  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> (back_status.busy && back_status.converting))
    else $error("back end did not start after pop");

  // A new character only appears from a busy back end
  a_char_source: assert property (@(posedge clk) disable iff (rst)
    $rose(chars.valid) |-> $past(back_status.busy))
    else $error("character emitted while back end idle");
`endif

endmodule

/* src/itda_front.sv */
// Front end: accepts word items, classifies sign and forms the magnitude.
module itda_front #(
  parameter int WORD_BITS = 32
) (
  itda_word_if.sink            words,
  output logic                 push_valid,
  output logic [WORD_BITS:0]   push_data,
  input  logic                 push_ready
);

  logic                 negative;
  logic [WORD_BITS-1:0] magnitude;

  // Negative only in signed mode with the top bit set
  assign negative  = (words.command == itda_pkg::CMD_SIGNED) && words.value[WORD_BITS-1];
  // Two's complement negate; the most negative value maps to 2^(WORD_BITS-1)
  assign magnitude = negative ? (~words.value + {{(WORD_BITS-1){1'b0}}, 1'b1})
                              : words.value;

  assign push_valid  = words.valid;
  assign push_data   = {negative, magnitude};
  assign words.ready = push_ready;

endmodule

/* src/itda_queue.sv */
// Two-entry queue between front and back ends.
module itda_queue #(
  parameter int WIDTH = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  input  logic             pop_ready
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/itda_back.sv */
// Back end: shift-add-3 conversion to BCD, then character emission MSD first.
module itda_back #(
  parameter int WORD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pop_valid,
  input  logic [WORD_BITS:0]      pop_data,
  output logic                    pop_ready,
  itda_char_if.source             chars,
  output itda_pkg::back_status_t  status
);

  // Decimal digits needed for WORD_BITS bits: floor(WORD_BITS*log10(2)) + 1
  localparam int NDIG   = (WORD_BITS * 30103) / 100000 + 1;
  localparam int CNT_W  = $clog2(WORD_BITS);
  localparam int PTR_W  = $clog2(NDIG);
  localparam int BCD_W  = 4 * NDIG;

  itda_pkg::back_state_t state, state_next;
  logic [WORD_BITS-1:0]  mag, mag_next;
  logic [BCD_W-1:0]      bcd, bcd_next;
  logic [BCD_W-1:0]      bcd_adj;
  logic                  sign_pend, sign_pend_next;
  logic                  started, started_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic [PTR_W-1:0]      ptr, ptr_next;
  logic                  ovalid, ovalid_next;
  logic [7:0]            ochar, ochar_next;
  logic                  olast, olast_next;
  logic                  slot;
  logic [3:0]            top_digit;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? (bcd[4*i +: 4] + 4'd3)
                                                   : bcd[4*i +: 4];
    end
  end

  assign slot      = !ovalid || chars.ready;
  assign top_digit = bcd[BCD_W-1 -: 4];

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= itda_pkg::BK_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mag       <= mag_next;
    bcd       <= bcd_next;
    sign_pend <= sign_pend_next;
    started   <= started_next;
    cnt       <= cnt_next;
    ptr       <= ptr_next;
    ochar     <= ochar_next;
    olast     <= olast_next;
  end

  // Sequencer
  always_comb begin
    state_next     = state;
    mag_next       = mag;
    bcd_next       = bcd;
    sign_pend_next = sign_pend;
    started_next   = started;
    cnt_next       = cnt;
    ptr_next       = ptr;
    ochar_next     = ochar;
    olast_next     = olast;
    ovalid_next    = ovalid && !chars.ready;
    pop_ready      = 1'b0;

    unique case (state)
      itda_pkg::BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          mag_next       = pop_data[WORD_BITS-1:0];
          sign_pend_next = pop_data[WORD_BITS];
          bcd_next       = '0;
          cnt_next       = '0;
          started_next   = 1'b0;
          state_next     = itda_pkg::BK_CONV;
        end
      end
      itda_pkg::BK_CONV: begin
        bcd_next = {bcd_adj[BCD_W-2:0], mag[WORD_BITS-1]};
        mag_next = {mag[WORD_BITS-2:0], 1'b0};
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(WORD_BITS - 1)) begin
          ptr_next   = PTR_W'(NDIG - 1);
          state_next = itda_pkg::BK_EMIT;
        end
      end
      itda_pkg::BK_EMIT: begin
        if (slot) begin
          if (sign_pend) begin
            sign_pend_next = 1'b0;
            ochar_next     = itda_pkg::ASCII_MINUS;
            olast_next     = 1'b0;
            ovalid_next    = 1'b1;
          end else if (top_digit == 4'd0 && !started && ptr != '0) begin
            // Leading zero: drop it
            bcd_next = {bcd[BCD_W-5:0], 4'd0};
            ptr_next = ptr - PTR_W'(1);
          end else begin
            started_next = 1'b1;
            ochar_next   = itda_pkg::ASCII_ZERO + {4'd0, top_digit};
            olast_next   = (ptr == '0);
            ovalid_next  = 1'b1;
            bcd_next     = {bcd[BCD_W-5:0], 4'd0};
            if (ptr == '0) begin
              state_next = itda_pkg::BK_IDLE;
            end else begin
              ptr_next = ptr - PTR_W'(1);
            end
          end
        end
      end
      default: state_next = itda_pkg::BK_IDLE;
    endcase
  end

  assign chars.valid       = ovalid;
  assign chars.character   = ochar;
  assign chars.last        = olast;
  assign status.busy       = (state != itda_pkg::BK_IDLE);
  assign status.converting = (state == itda_pkg::BK_CONV);

endmodule
